@@ hdl/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

    localparam int SYMBOL_COUNT  = 256;
    localparam int WORD_BITS     = 32;
    localparam int LEN_BITS      = 6;
    localparam int BYTE_BITS     = 8;
    localparam int MAX_CODE_LEN  = 32;
    localparam int CODE_CAP      = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam logic [LEN_BITS-1:0] CODE_CAP_LEN = LEN_BITS'(CODE_CAP);
    localparam int ENTRY_BITS    = WORD_BITS + LEN_BITS;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } hcbp_op_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [7:0]           symbol;
        logic [WORD_BITS-1:0] code_word;
        logic [LEN_BITS-1:0]  code_length;
    } hcbp_in_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] packed_byte;
        logic                 last_of_run;
        logic [31:0]          byte_total;
    } hcbp_out_t;

    // Work handed from the front end to the packer.
    typedef struct packed {
        logic                 flush;
        logic [WORD_BITS-1:0] word;
        logic [LEN_BITS-1:0]  len;
    } hcbp_cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_ENCODE
    } hcbp_bk_state_t;

endpackage

@@ hdl/huffman_code_bit_packer.sv @@
// Huffman code bit packer: top level joining front end, queue and byte packer.
// An encode's first byte passes the table read and the queue push, then a pack step
// into the output register before it is offered.
// Loads go straight to the code table and never reach the packer; an encode takes one
// packer step per byte boundary, and a flush a single packer step.
// Reset: asynchronous, active low; clears loaded flags, accumulator, fill, count, queue.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
    input  logic                clk,
    input  logic                rst_n,
    // input item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  hcbp_pkg::hcbp_in_t  item,
    // result byte channel
    output logic                result_valid,
    input  logic                result_stall,
    output hcbp_pkg::hcbp_out_t result
);

    // front end -> queue
    logic                push;
    hcbp_pkg::hcbp_cmd_t push_cmd;
    logic                q_full;

    // queue -> packer
    logic                pop;
    logic                head_valid;
    hcbp_pkg::hcbp_cmd_t head;

    // Front end: loads go straight to the code table RAM; encodes read it and
    // flushes pass through, both parked in a stage register then pushed as commands.
    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    // Decouples table lookup from byte packing so loads keep flowing while
    // the packer works through a long code or waits on a stalled transfer.
    hcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Packer: fills the byte accumulator MSB first and emits each full byte
    // (or a padded partial byte on flush) into the output register.
    hcbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ hdl/hcbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/hcbp_front.sv @@
// Front end: takes items, owns the code table, issues encode/flush work.
module hcbp_front #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hcbp_pkg::hcbp_in_t  item,
    output logic                push,
    output hcbp_pkg::hcbp_cmd_t push_cmd,
    input  logic                q_full
);

    localparam int AW       = $clog2(hcbp_pkg::SYMBOL_COUNT);
    localparam int LW       = hcbp_pkg::LEN_BITS;
    localparam int CODE_CAP = (MAX_CODE_LEN < hcbp_pkg::WORD_BITS) ? MAX_CODE_LEN
                                                                   : hcbp_pkg::WORD_BITS;
    localparam logic [LW-1:0] CODE_CAP_LEN = LW'(CODE_CAP);

    logic                                accept;
    logic                                is_load;
    logic                                is_work;
    logic [hcbp_pkg::LEN_BITS-1:0]       len_clamped;
    logic [hcbp_pkg::ENTRY_BITS-1:0]     rd_entry;
    logic [hcbp_pkg::SYMBOL_COUNT-1:0]   loaded_reg;
    logic [hcbp_pkg::SYMBOL_COUNT-1:0]   loaded_next;
    logic                                stage_valid_reg;
    logic                                stage_valid_next;
    logic                                stage_flush_reg;
    logic                                stage_hit_reg;

    assign item_stall = stage_valid_reg && q_full;
    assign accept     = item_valid && !item_stall;
    assign is_load    = (item.operation == hcbp_pkg::OP_LOAD);
    assign is_work    = (item.operation == hcbp_pkg::OP_ENCODE)
                     || (item.operation == hcbp_pkg::OP_FLUSH);
    assign len_clamped = (item.code_length > CODE_CAP_LEN)
                       ? CODE_CAP_LEN : item.code_length;

    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_BITS),
        .DEPTH (hcbp_pkg::SYMBOL_COUNT)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (accept && is_load),
        .wr_addr (item.symbol[AW-1:0]),
        .wr_data ({item.code_word, len_clamped}),
        .rd_en   (accept && (item.operation == hcbp_pkg::OP_ENCODE)),
        .rd_addr (item.symbol[AW-1:0]),
        .rd_data (rd_entry)
    );

    assign push = stage_valid_reg && !q_full;

    always_comb
    begin
        push_cmd.flush = stage_flush_reg;
        push_cmd.word  = rd_entry[hcbp_pkg::ENTRY_BITS-1:hcbp_pkg::LEN_BITS];
        // never-loaded entries read as empty codes
        push_cmd.len   = stage_hit_reg ? rd_entry[hcbp_pkg::LEN_BITS-1:0]
                                       : '0;
    end

    always_comb
    begin
        loaded_next = loaded_reg;
        if (accept && is_load)
        begin
            loaded_next[item.symbol[AW-1:0]] = 1'b1;
        end
        stage_valid_next = stage_valid_reg && !push;
        if (accept && is_work)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg      <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg      <= loaded_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_work)
        begin
            stage_flush_reg <= (item.operation == hcbp_pkg::OP_FLUSH);
            stage_hit_reg   <= loaded_reg[item.symbol[AW-1:0]];
        end
    end

endmodule

@@ hdl/hcbp_queue.sv @@
// Short command queue between front end and packer.
module hcbp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hcbp_pkg::hcbp_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output hcbp_pkg::hcbp_cmd_t head
);

    localparam int PW = $clog2(hcbp_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(hcbp_pkg::QUEUE_DEPTH + 1);

    hcbp_pkg::hcbp_cmd_t slot_reg [hcbp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CW'(hcbp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'((int'(wr_ptr_reg) + 1) % hcbp_pkg::QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'((int'(rd_ptr_reg) + 1) % hcbp_pkg::QUEUE_DEPTH);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/hcbp_back.sv @@
// Back end: packs code bits into bytes, one byte step per cycle while the output register is free.
module hcbp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  hcbp_pkg::hcbp_cmd_t head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output hcbp_pkg::hcbp_out_t result
);

    hcbp_pkg::hcbp_bk_state_t state_reg;
    hcbp_pkg::hcbp_bk_state_t state_next;

    logic [hcbp_pkg::WORD_BITS-1:0] word_reg;
    logic [hcbp_pkg::LEN_BITS-1:0]  rem_reg;
    logic [7:0]                     acc_reg;
    logic [2:0]                     fill_reg;
    logic [31:0]                    count_reg;
    logic                           out_valid_reg;
    hcbp_pkg::hcbp_out_t            out_reg;

    logic                           out_free;
    logic                           do_step;
    logic                           do_flush;
    logic                           emit;
    logic [7:0]                     emit_byte;
    logic                           emit_last;
    logic [hcbp_pkg::WORD_BITS-1:0] cur_word;
    logic [hcbp_pkg::LEN_BITS-1:0]  cur_rem;
    logic [3:0]                     space;
    logic [3:0]                     take;
    logic [hcbp_pkg::WORD_BITS-1:0] shifted;
    logic [7:0]                     chunk;
    logic [7:0]                     acc_new;
    logic [3:0]                     fill_sum;
    logic [hcbp_pkg::LEN_BITS-1:0]  rem_after;
    logic [31:0]                    count_inc;

    assign out_free = !out_valid_reg || !result_stall;

    // one step: move up to the free bit positions from the code into the byte
    always_comb
    begin
        cur_word = (state_reg == hcbp_pkg::BK_IDLE) ? head.word : word_reg;
        cur_rem  = (state_reg == hcbp_pkg::BK_IDLE) ? head.len  : rem_reg;
        space    = 4'd8 - {1'b0, fill_reg};
        take     = (cur_rem < {2'b00, space}) ? cur_rem[3:0] : space;
        rem_after = cur_rem - {2'b00, take};
        shifted  = cur_word >> rem_after;
        chunk    = shifted[7:0] & (8'hFF >> (4'd8 - take));
        acc_new  = acc_reg | (chunk << (space - take));
        fill_sum = {1'b0, fill_reg} + take;
        count_inc = (count_reg == '1) ? count_reg : count_reg + 32'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcbp_pkg::BK_IDLE:
            begin
                if (head_valid && out_free && !head.flush && (rem_after != '0))
                begin
                    state_next = hcbp_pkg::BK_ENCODE;
                end
            end
            hcbp_pkg::BK_ENCODE:
            begin
                if (out_free && (rem_after == '0))
                begin
                    state_next = hcbp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = hcbp_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        do_step  = 1'b0;
        do_flush = 1'b0;
        unique case (state_reg)
            hcbp_pkg::BK_IDLE:
            begin
                pop      = head_valid && out_free;
                do_step  = pop && !head.flush;
                do_flush = pop && head.flush;
            end
            hcbp_pkg::BK_ENCODE:
            begin
                do_step = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        emit      = 1'b0;
        emit_byte = acc_new;
        // no further byte once fewer than eight code bits remain
        emit_last = (rem_after < 6'd8);
        if (do_step && (fill_sum == 4'd8))
        begin
            emit = 1'b1;
        end
        else if (do_flush && (fill_reg != '0))
        begin
            emit      = 1'b1;
            emit_byte = acc_reg;
            emit_last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcbp_pkg::BK_IDLE;
            acc_reg       <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                acc_reg   <= '0;
                fill_reg  <= '0;
                count_reg <= count_inc;
            end
            else if (do_step)
            begin
                acc_reg  <= acc_new;
                fill_reg <= fill_sum[2:0];
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            word_reg <= cur_word;
            rem_reg  <= rem_after;
        end
        if (emit)
        begin
            out_reg.packed_byte <= emit_byte;
            out_reg.last_of_run <= emit_last;
            out_reg.byte_total  <= count_inc;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ hdl/hcbp_checker.sv @@
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input hcbp_pkg::hcbp_out_t result
);

    logic [31:0] last_total_reg;
    logic        xfer;

    assign xfer = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (xfer)
        begin
            last_total_reg <= result.byte_total;
        end
    end

    // nothing is offered on the result side during reset
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // every transferred byte counts up by one, saturating at the top
    a_total_steps: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> (result.byte_total == last_total_reg + 32'd1)
              || ((last_total_reg == '1) && (result.byte_total == '1)))
        else $error("byte total out of sequence");

    // the input side stalls only when a command is already waiting
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> $past(item_valid && !item_stall) || $past(item_stall))
        else $error("input stalled with no work taken");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ bench/tb_huffman_code_bit_packer.sv @@
// Self-checking bench for huffman_code_bit_packer: table loads, encodes and flushes.
module tb_huffman_code_bit_packer;

    // Operation code 3 has no meaning; the block must drop it without a trace.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 335;
    // Longest correct quiet stretch: a sender gap + a receiver stall run
    // + the packer steps of one encode + the pipeline latency. The limit is far above that.
    localparam int QUIET_LIMIT  = 500;
    // Covers the wait from an item to its first byte and the packer steps of a long encode.
    localparam int DRAIN_CYCLES = 16;

    // Receiver stall patterns, stepped through in turn.
    localparam int RX_FREE        = 0;
    localparam int RX_RANDOM      = 1;
    localparam int RX_EVERY_THIRD = 2;
    localparam int RX_BLOCKS      = 3;

    typedef struct {
        hcbp_pkg::hcbp_in_t stim;
        int                 want_count;   // -1: expected bytes come from the packing model
        logic [7:0]         want_byte;    // every typed byte of the row has this value
    } plan_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    hcbp_pkg::hcbp_in_t  item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    hcbp_pkg::hcbp_out_t result;

    huffman_code_bit_packer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Packing model: code table, partial byte and the saturating byte count.
    // ------------------------------------------------------------------
    logic [hcbp_pkg::WORD_BITS-1:0] code_bits [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::LEN_BITS-1:0]  code_size [hcbp_pkg::SYMBOL_COUNT];
    logic [7:0]                     pend_byte;
    int                             pend_fill;
    logic [31:0]                    bytes_out;

    hcbp_pkg::hcbp_out_t fresh_bytes [$];    // bytes caused by the item just taken in
    hcbp_pkg::hcbp_out_t awaited_bytes [$];  // bytes the block still owes, oldest first
    logic [7:0]          loaded_syms [$];    // symbols with a load behind them, for encodes

    int mismatches    = 0;
    int bytes_checked = 0;
    int op_tally [4]  = '{0, 0, 0, 0};
    int burst_left    = 0;
    int rx_cycle      = 0;
    int quiet_cycles  = 0;
    hcbp_pkg::hcbp_out_t oldest;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // Completed or flushed byte: bump the count, then clear the partial byte.
    task automatic pack_emit();
        hcbp_pkg::hcbp_out_t b;
        if (bytes_out != 32'hFFFF_FFFF)
            bytes_out++;
        b.packed_byte = pend_byte;
        b.last_of_run = 1'b0;
        b.byte_total  = bytes_out;
        fresh_bytes = {fresh_bytes, b};
        pend_byte = '0;
        pend_fill = 0;
    endtask

    task automatic pack_model(input hcbp_pkg::hcbp_in_t it);
        int                  n;
        hcbp_pkg::hcbp_out_t tail;
        fresh_bytes.delete();
        case (it.operation)
            hcbp_pkg::OP_LOAD:
            begin
                // lengths past the cap are clipped at load time
                code_bits[it.symbol] = it.code_word;
                code_size[it.symbol] = (it.code_length > hcbp_pkg::CODE_CAP_LEN)
                                     ? hcbp_pkg::CODE_CAP_LEN : it.code_length;
                loaded_syms = {loaded_syms, it.symbol};
            end
            hcbp_pkg::OP_ENCODE:
            begin
                // first code bit is the top one of the used bits; it lands in
                // the highest free position of the partial byte
                for (n = code_size[it.symbol]; n > 0; n--)
                begin
                    pend_byte[7 - pend_fill] = code_bits[it.symbol][n - 1];
                    pend_fill++;
                    if (pend_fill == hcbp_pkg::BYTE_BITS)
                        pack_emit();
                end
            end
            hcbp_pkg::OP_FLUSH:
            begin
                if (pend_fill != 0)
                    pack_emit();
            end
            default: ;
        endcase
        if (fresh_bytes.size() > 0)
        begin
            tail = fresh_bytes[fresh_bytes.size() - 1];
            tail.last_of_run = 1'b1;
            fresh_bytes[fresh_bytes.size() - 1] = tail;
        end
    endtask

    function automatic plan_row_t plan_row(input logic [1:0] op, input logic [7:0] sym,
                                           input logic [31:0] word, input logic [5:0] len,
                                           input int n, input logic [7:0] b);
        plan_row_t row;
        row.stim       = '{operation: op, symbol: sym, code_word: word, code_length: len};
        row.want_count = n;
        row.want_byte  = b;
        return row;
    endfunction

    // Random item: mostly encodes of loaded symbols, loads with mostly short
    // codes, some flushes and a trickle of the unused code.
    function automatic hcbp_pkg::hcbp_in_t draw_item();
        hcbp_pkg::hcbp_in_t it;
        int                 pick;
        int                 span;
        it.symbol      = 8'($urandom);
        it.code_word   = $urandom;
        it.code_length = 6'($urandom_range(1, 12));
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            it.operation = hcbp_pkg::OP_LOAD;
            span = $urandom_range(0, 19);
            if (span == 0)
                it.code_length = '0;
            else if (span == 1)
                it.code_length = 6'($urandom_range(33, 63));
            else if (span < 5)
                it.code_length = 6'($urandom_range(25, 32));
        end
        else if (pick < 80)
        begin
            it.operation = hcbp_pkg::OP_ENCODE;
            if (loaded_syms.size() > 0 && $urandom_range(0, 99) < 85)
                it.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end
        else if (pick < 96)
            it.operation = hcbp_pkg::OP_FLUSH;
        else
            it.operation = OP_SPARE;
        return it;
    endfunction

    // Offer one item in the current burst, wait for its transfer, then queue
    // the bytes it owes. Called just after a falling edge.
    task automatic offer_item(input hcbp_pkg::hcbp_in_t it, input int want_count,
                              input logic [7:0] want_byte);
        int                  gap;
        int                  k;
        logic [31:0]         total;
        hcbp_pkg::hcbp_out_t want;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // transfer happened at this edge
        total = bytes_out;
        pack_model(it);
        op_tally[it.operation]++;
        if (want_count < 0)
        begin
            awaited_bytes = {awaited_bytes, fresh_bytes};
        end
        else
        begin
            for (k = 0; k < want_count; k++)
            begin
                if (total != 32'hFFFF_FFFF)
                    total++;
                want.packed_byte = want_byte;
                want.last_of_run = (k == want_count - 1);
                want.byte_total  = total;
                awaited_bytes = {awaited_bytes, want};
            end
        end
        @(negedge clk);
    endtask

    // Hold the sender off until the block has delivered everything it owes.
    task automatic settle_out();
        item_valid <= 1'b0;
        burst_left = 0;
        while (awaited_bytes.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall patterns and the byte checker.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 4)
            RX_FREE:        result_stall <= 1'b0;
            RX_RANDOM:      result_stall <= ($urandom_range(0, 3) == 0);
            RX_EVERY_THIRD: result_stall <= (rx_cycle % 3 == 0);
            default:        result_stall <= ((rx_cycle % 13) < 6);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_bytes.size() == 0)
                report_mismatch($sformatf("byte %02h with nothing outstanding",
                                          result.packed_byte));
            else
            begin
                oldest = awaited_bytes.pop_front();
                bytes_checked++;
                if (result.packed_byte !== oldest.packed_byte)
                    report_mismatch($sformatf("packed_byte %02h, want %02h",
                                              result.packed_byte, oldest.packed_byte));
                if (result.last_of_run !== oldest.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b on byte %0d",
                                              result.last_of_run, oldest.last_of_run,
                                              oldest.byte_total));
                if (result.byte_total !== oldest.byte_total)
                    report_mismatch($sformatf("byte_total %0d, want %0d",
                                              result.byte_total, oldest.byte_total));
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: %0d cycles without a transfer", quiet_cycles);
                $display("FAIL huffman_code_bit_packer");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t plan [$];
        int        r;
        for (r = 0; r < hcbp_pkg::SYMBOL_COUNT; r++)
        begin
            code_bits[r] = '0;
            code_size[r] = '0;
        end
        pend_byte = '0;
        pend_fill = 0;
        bytes_out = '0;

        // Directed rows. Typed counts and bytes where they are obvious.
        // never loaded symbol after reset: nothing comes out
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h41, 32'h0, 6'd0, 0, 8'h00)};
        // flush with nothing pending
        plan = {plan, plan_row(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, 0, 8'h00)};
        // unused code with junk fields
        plan = {plan, plan_row(OP_SPARE, 8'hA5, 32'hFFFF_FFFF, 6'd32, 0, 8'h00)};
        // widest all-ones code: four full bytes
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 0, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0, 4, 8'hFF)};
        // length 63 clipped to 32 on load
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'h00, 32'h0, 6'd63, 0, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 4, 8'h00)};
        // single-symbol alphabet: one-bit zero code, upper word bits ignored
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'h10, 32'hFFFF_FFFE, 6'd1, 0, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h10, 32'h0, 6'd0, 0, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, 1, 8'h00)};
        // short code then an unaligned 33-bit load (clipped) straddling bytes
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'h01, 32'h0000_0005, 6'd3, -1, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h01, 32'h0, 6'd0, -1, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd33, -1, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h80, 32'h0, 6'd0, -1, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, -1, 8'h00)};
        // single one bit padded out by a flush
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'h02, 32'h0000_0001, 6'd1, 0, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h02, 32'h0, 6'd0, 0, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, 1, 8'h80)};
        // zero length load: symbol has no code
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'h03, 32'h1234_5678, 6'd0, 0, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h03, 32'h0, 6'd0, 0, 8'h00)};
        // 31-bit code leaves 7 bits; the 32-bit ones code then leaves 7 ones
        plan = {plan, plan_row(hcbp_pkg::OP_LOAD, 8'h7F, 32'hDEAD_BEEF, 6'd31, -1, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'h7F, 32'h0, 6'd0, -1, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0, -1, 8'h00)};
        plan = {plan, plan_row(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, 1, 8'hFE)};
        plan = {plan, plan_row(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 8'h00)};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            offer_item(plan[i].stim, plan[i].want_count, plan[i].want_byte);
        settle_out();

        for (r = 0; r < RANDOM_ITEMS; r++)
        begin
            // one full drain in the middle of the random traffic
            if (r == RANDOM_ITEMS / 2)
                settle_out();
            offer_item(draw_item(), -1, 8'h00);
        end
        settle_out();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Items: %0d loads, %0d encodes, %0d flushes, %0d unused-code",
                 op_tally[hcbp_pkg::OP_LOAD], op_tally[hcbp_pkg::OP_ENCODE],
                 op_tally[hcbp_pkg::OP_FLUSH], op_tally[OP_SPARE]);
        $display("Bytes checked: %0d, mismatches: %0d", bytes_checked, mismatches);
        if (mismatches == 0)
            $display("PASS huffman_code_bit_packer");
        else
            $display("FAIL huffman_code_bit_packer");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/hcbp_pkg.sv
hdl/hcbp_ram.sv
hdl/hcbp_front.sv
hdl/hcbp_queue.sv
hdl/hcbp_back.sv
hdl/huffman_code_bit_packer.sv
hdl/hcbp_checker.sv
bench/tb_huffman_code_bit_packer.sv
